/* sv/scp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scp_pkg
// shared types and constants for the second-chance page replacement core
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int FAULT_W     = 32;
    localparam int FRAME_IDX_W = 4;
    localparam int ACTIVE_W    = 5;
    localparam int APB_ADDR_W  = 2;
    localparam int APB_DATA_W  = 32;

    localparam logic [ACTIVE_W-1:0]   ACTIVE_FRAMES_RESET = 5'd10;
    localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE_FRAMES  = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_WRITE,
        ST_FINISH
    } scp_state_t;

    // one operation on the frame table per cycle, all at the same frame
    typedef struct packed {
        logic wr;       // load page, set valid and reference bit
        logic set_ref;  // hit: set reference bit
        logic clr_ref;  // sweep: clear reference bit
    } scp_store_cmd_t;

endpackage

`default_nettype wire

/* sv/scp_frame_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scp_frame_store
// page number memory with registered read, plus valid and reference bits
// ----------------------------------------------------------------------------
module scp_frame_store
    import scp_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 20,
    localparam int IW = $clog2(MAX_FRAMES)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire scp_store_cmd_t        cmd,
    input  wire logic [IW-1:0]         op_addr,
    input  wire logic [PAGE_BITS-1:0]  wr_page,
    input  wire logic [IW-1:0]         rd_addr,
    output logic      [PAGE_BITS-1:0]  rd_page,
    output logic      [MAX_FRAMES-1:0] valid_vec,
    output logic      [MAX_FRAMES-1:0] ref_vec
);

    logic [PAGE_BITS-1:0]  page_mem [MAX_FRAMES];
    logic [PAGE_BITS-1:0]  rd_page_reg;
    logic [MAX_FRAMES-1:0] valid_reg;
    logic [MAX_FRAMES-1:0] ref_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            page_mem[op_addr] <= wr_page;
        end
        rd_page_reg <= page_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ref_reg   <= '0;
        end
        else if (cmd.wr)
        begin
            valid_reg[op_addr] <= 1'b1;
            ref_reg[op_addr]   <= 1'b1;
        end
        else if (cmd.set_ref)
        begin
            ref_reg[op_addr] <= 1'b1;
        end
        else if (cmd.clr_ref)
        begin
            ref_reg[op_addr] <= 1'b0;
        end
    end

    assign rd_page   = rd_page_reg;
    assign valid_vec = valid_reg;
    assign ref_vec   = ref_reg;

endmodule

`default_nettype wire

/* sv/scp_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scp_seq
// sequencer: serial tag scan, fill, clock-hand sweep and fault count
// ----------------------------------------------------------------------------
module scp_seq
    import scp_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 20,
    localparam int IW = $clog2(MAX_FRAMES),
    localparam int CW = $clog2(MAX_FRAMES + 1)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [ACTIVE_W-1:0]   active_frames,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [PAGE_BITS-1:0]  page_in,
    output scp_store_cmd_t             cmd,
    output logic      [IW-1:0]         op_addr,
    output logic      [PAGE_BITS-1:0]  wr_page,
    output logic      [IW-1:0]         rd_addr,
    input  wire logic [PAGE_BITS-1:0]  rd_page,
    input  wire logic [MAX_FRAMES-1:0] valid_vec,
    input  wire logic [MAX_FRAMES-1:0] ref_vec,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic                       res_hit,
    output logic      [IW-1:0]         res_frame,
    output logic                       res_ev_valid,
    output logic      [PAGE_BITS-1:0]  res_ev_page,
    output logic      [FAULT_W-1:0]    res_faults
);

    scp_state_t           state_reg,    state_next;
    logic [CW-1:0]        scan_idx_reg, scan_idx_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [IW-1:0]        hand_reg,     hand_next;
    logic [CW-1:0]        fill_reg,     fill_next;
    logic [FAULT_W-1:0]   fault_reg,    fault_next;

    logic [PAGE_BITS-1:0] page_reg,     page_next;
    logic [CW-1:0]        n_reg,        n_next;
    logic [IW-1:0]        chk_idx_reg,  chk_idx_next;
    logic                 hit_reg,      hit_next;
    logic [IW-1:0]        victim_reg,   victim_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [PAGE_BITS-1:0] ev_page_reg,  ev_page_next;

    logic                 issue;
    logic                 hit_now;

    function automatic logic [IW-1:0] hand_step(input logic [IW-1:0] h,
                                                input logic [CW-1:0] n);
        logic [CW-1:0] nxt;
        nxt = CW'(h) + CW'(1);
        hand_step = (nxt >= n) ? '0 : nxt[IW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
            hand_reg      <= '0;
            fill_reg      <= '0;
            fault_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            chk_valid_reg <= chk_valid_next;
            hand_reg      <= hand_next;
            fill_reg      <= fill_next;
            fault_reg     <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg     <= page_next;
        n_reg        <= n_next;
        chk_idx_reg  <= chk_idx_next;
        hit_reg      <= hit_next;
        victim_reg   <= victim_next;
        ev_valid_reg <= ev_valid_next;
        ev_page_reg  <= ev_page_next;
    end

    assign issue   = (scan_idx_reg < n_reg);
    assign hit_now = chk_valid_reg && valid_vec[chk_idx_reg] && (rd_page == page_reg);

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = 1'b0;
        hand_next      = hand_reg;
        fill_next      = fill_reg;
        fault_next     = fault_reg;
        page_next      = page_reg;
        n_next         = n_reg;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        victim_next    = victim_reg;
        ev_valid_next  = ev_valid_reg;
        ev_page_next   = ev_page_reg;

        cmd       = '0;
        op_addr   = victim_reg;
        wr_page   = page_reg;
        rd_addr   = scan_idx_reg[IW-1:0];
        in_ready  = 1'b0;
        res_valid = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    page_next     = page_in;
                    scan_idx_next = '0;
                    // zero acts as one frame, anything above the build as all
                    if (active_frames == '0)
                    begin
                        n_next = CW'(1);
                    end
                    else if (int'(active_frames) > MAX_FRAMES)
                    begin
                        n_next = CW'(MAX_FRAMES);
                    end
                    else
                    begin
                        n_next = CW'(active_frames);
                    end
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // one frame read issued and one compared per cycle
                rd_addr        = scan_idx_reg[IW-1:0];
                chk_valid_next = issue;
                chk_idx_next   = scan_idx_reg[IW-1:0];
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (hit_now)
                begin
                    cmd.set_ref    = 1'b1;
                    op_addr        = chk_idx_reg;
                    chk_valid_next = 1'b0;
                    hit_next       = 1'b1;
                    victim_next    = chk_idx_reg;
                    ev_valid_next  = 1'b0;
                    ev_page_next   = '0;
                    state_next     = ST_FINISH;
                end
                else if (!issue && !chk_valid_reg)
                begin
                    hit_next = 1'b0;
                    if (fault_reg != '1)
                    begin
                        fault_next = fault_reg + FAULT_W'(1);
                    end
                    if (fill_reg < n_reg)
                    begin
                        victim_next   = fill_reg[IW-1:0];
                        fill_next     = fill_reg + CW'(1);
                        ev_valid_next = 1'b0;
                        state_next    = ST_WRITE;
                    end
                    else
                    begin
                        if (CW'(hand_reg) >= n_reg)
                        begin
                            hand_next = '0;
                        end
                        state_next = ST_SWEEP;
                    end
                end
            end

            ST_SWEEP:
            begin
                rd_addr   = hand_reg;
                op_addr   = hand_reg;
                hand_next = hand_step(hand_reg, n_reg);
                if (valid_vec[hand_reg] && ref_vec[hand_reg])
                begin
                    cmd.clr_ref = 1'b1;
                end
                else
                begin
                    victim_next   = hand_reg;
                    ev_valid_next = valid_vec[hand_reg];
                    state_next    = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                cmd.wr       = 1'b1;
                op_addr      = victim_reg;
                ev_page_next = ev_valid_reg ? rd_page : '0;
                state_next   = ST_FINISH;
            end

            ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_hit      = hit_reg;
    assign res_frame    = victim_reg;
    assign res_ev_valid = ev_valid_reg;
    assign res_ev_page  = ev_page_reg;
    assign res_faults   = fault_reg;

endmodule

`default_nettype wire

/* sv/second_chance_page_replacement_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// second_chance_page_replacement_core
// clock (second-chance) page replacement over a small frame table
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid/in_ready, page_number            | in
//  output   | out_valid/out_ready, hit, frame_index,    | out
//           | evicted_valid, evicted_page, fault_total  |
//  config   | psel/penable/pwrite/paddr/pwdata/prdata   | apb
//
//  n = active frames after clamping; one comparator walks the table a frame
//  a cycle. a hit in frame j stops the scan there; a miss scans all n frames,
//  then fills a free frame or sweeps, clearing reference bits (at most n)
//  reset clears valid and reference bits, hand, fill and fault counts, not
//  the page memory. a new item is taken while the last result still waits;
//  the sequencer stalls only in its finish step while that register is full
// ----------------------------------------------------------------------------
module second_chance_page_replacement_core
    import scp_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 20
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // config port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic      [APB_DATA_W-1:0]  prdata,
    output logic                        pready,

    // page reference in
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [PAGE_BITS-1:0]   page_number,

    // result out
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        hit,
    output logic      [FRAME_IDX_W-1:0] frame_index,
    output logic                        evicted_valid,
    output logic      [PAGE_BITS-1:0]   evicted_page,
    output logic      [FAULT_W-1:0]     fault_total
);

    localparam int IW = $clog2(MAX_FRAMES);

    // config register
    logic [ACTIVE_W-1:0]    active_frames_reg;
    logic                   cfg_wr;

    // sequencer <-> frame table
    scp_store_cmd_t         cmd;
    logic [IW-1:0]          op_addr;
    logic [PAGE_BITS-1:0]   wr_page;
    logic [IW-1:0]          rd_addr;
    logic [PAGE_BITS-1:0]   rd_page;
    logic [MAX_FRAMES-1:0]  valid_vec;
    logic [MAX_FRAMES-1:0]  ref_vec;

    // sequencer result
    logic                   res_valid;
    logic                   res_ready;
    logic                   res_hit;
    logic [IW-1:0]          res_frame;
    logic                   res_ev_valid;
    logic [PAGE_BITS-1:0]   res_ev_page;
    logic [FAULT_W-1:0]     res_faults;

    // output register
    logic                   out_valid_reg;
    logic                   hit_reg;
    logic [FRAME_IDX_W-1:0] frame_index_reg;
    logic                   evicted_valid_reg;
    logic [PAGE_BITS-1:0]   evicted_page_reg;
    logic [FAULT_W-1:0]     fault_total_reg;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_frames_reg <= ACTIVE_FRAMES_RESET;
        end
        else if (cfg_wr && (paddr == ADDR_ACTIVE_FRAMES))
        begin
            active_frames_reg <= pwdata[ACTIVE_W-1:0];
        end
    end

    // reads of unmapped addresses return zero
    assign prdata = (paddr == ADDR_ACTIVE_FRAMES) ?
                    APB_DATA_W'(active_frames_reg) : '0;

    // ---------------- frame table ----------------
    scp_frame_store #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .op_addr   (op_addr),
        .wr_page   (wr_page),
        .rd_addr   (rd_addr),
        .rd_page   (rd_page),
        .valid_vec (valid_vec),
        .ref_vec   (ref_vec)
    );

    // ---------------- sequencer ----------------
    scp_seq #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .active_frames (active_frames_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .page_in       (page_number),
        .cmd           (cmd),
        .op_addr       (op_addr),
        .wr_page       (wr_page),
        .rd_addr       (rd_addr),
        .rd_page       (rd_page),
        .valid_vec     (valid_vec),
        .ref_vec       (ref_vec),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_hit       (res_hit),
        .res_frame     (res_frame),
        .res_ev_valid  (res_ev_valid),
        .res_ev_page   (res_ev_page),
        .res_faults    (res_faults)
    );

    // ---------------- output register ----------------
    // free when empty or when its content leaves in this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            hit_reg           <= res_hit;
            // frame number shown modulo sixteen
            frame_index_reg   <= FRAME_IDX_W'(res_frame);
            evicted_valid_reg <= res_ev_valid;
            evicted_page_reg  <= res_ev_page;
            fault_total_reg   <= res_faults;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_total   = fault_total_reg;

endmodule

`default_nettype wire

/* sv/scp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scp_checker
// port-level checks for the second-chance page replacement core
// ----------------------------------------------------------------------------
module scp_checker
    import scp_pkg::*;
#(
    parameter int PAGE_BITS = 20
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic                   hit,
    input wire logic [FRAME_IDX_W-1:0] frame_index,
    input wire logic                   evicted_valid,
    input wire logic [PAGE_BITS-1:0]   evicted_page,
    input wire logic [FAULT_W-1:0]     fault_total
);

    // a hit never replaces anything
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted_valid))
    else $error("hit reported together with an eviction");

    // no eviction means a zero evicted page
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !evicted_valid) |-> (evicted_page == '0))
    else $error("evicted page nonzero without eviction");

    // one item at a time: busy in the cycle after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a transfer");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(fault_total) && $stable(frame_index) && $stable(hit)))
    else $error("stalled result changed");

endmodule

bind second_chance_page_replacement_core scp_checker #(
    .PAGE_BITS (PAGE_BITS)
) u_scp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
);

`default_nettype wire

/* verif/second_chance_page_replacement_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_chance_page_replacement_core_tb
// self-checking bench: page references stream in with random gaps, an
// in-bench clock-replacement predictor tracks frames, hand and fault count,
// and every result transfer is compared field by field in arrival order
// ----------------------------------------------------------------------------

localparam int PAGE_W     = 20;
localparam int NUM_FRAMES = 16;

class page_table_scoreboard;

    typedef struct packed {
        logic                              hit;
        logic [scp_pkg::FRAME_IDX_W-1:0]   frame_index;
        logic                              evicted_valid;
        logic [PAGE_W-1:0]                 evicted_page;
        logic [scp_pkg::FAULT_W-1:0]       fault_total;
    } page_result_t;

    logic [PAGE_W-1:0]             frame_page [NUM_FRAMES];
    logic                          frame_valid [NUM_FRAMES];
    logic                          ref_bit [NUM_FRAMES];
    logic [3:0]                    hand;
    logic [4:0]                    filled;
    logic [scp_pkg::FAULT_W-1:0]   faults;
    logic [scp_pkg::ACTIVE_W-1:0]  active_frames;
    page_result_t                  expected_results [$];
    int                            mismatch_count;

    function new();
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            frame_page[i]  = '0;
            frame_valid[i] = 1'b0;
            ref_bit[i]     = 1'b0;
        end
        hand           = '0;
        filled         = '0;
        faults         = '0;
        active_frames  = scp_pkg::ACTIVE_FRAMES_RESET;
        mismatch_count = 0;
    endfunction

    // update the frame table for one accepted reference and queue its result
    function void note_reference(logic [PAGE_W-1:0] page);
        int           n;
        int           victim;
        int           sweep_steps;
        bit           found;
        page_result_t r;
        n = (active_frames == 0) ? 1 :
            (active_frames > NUM_FRAMES) ? NUM_FRAMES : int'(active_frames);
        found  = 1'b0;
        victim = 0;
        r      = '0;
        for (int i = 0; i < n; i++)
        begin
            if (!found && frame_valid[i] && frame_page[i] == page)
            begin
                found         = 1'b1;
                ref_bit[i]    = 1'b1;
                r.hit         = 1'b1;
                r.frame_index = i[3:0];
                r.fault_total = faults;
            end
        end
        if (!found)
        begin
            if (faults != '1)
                faults = faults + 1'b1;
            if (filled < n)
            begin
                victim = int'(filled);
                filled = filled + 1'b1;
            end
            else
            begin
                if (hand >= n)
                    hand = '0;
                // pass over referenced frames, clearing their bits
                sweep_steps = 0;
                while (sweep_steps <= n && frame_valid[hand] && ref_bit[hand])
                begin
                    ref_bit[hand] = 1'b0;
                    hand = (int'(hand) + 1 >= n) ? 4'd0 : hand + 1'b1;
                    sweep_steps++;
                end
                victim = int'(hand);
                if (frame_valid[victim])
                begin
                    r.evicted_valid = 1'b1;
                    r.evicted_page  = frame_page[victim];
                end
                hand = (victim + 1 >= n) ? 4'd0 : hand + 1'b1;
            end
            frame_page[victim]  = page;
            frame_valid[victim] = 1'b1;
            ref_bit[victim]     = 1'b1;
            r.frame_index       = victim[3:0];
            r.fault_total       = faults;
        end
        expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ERROR: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function void check_result(page_result_t got);
        page_result_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t ERROR: result transfer with none pending, got 0x%0h",
                     $time, got);
            mismatch_count++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("hit", 32'(want.hit), 32'(got.hit));
        compare_field("frame_index", 32'(want.frame_index), 32'(got.frame_index));
        compare_field("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
        compare_field("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
        compare_field("fault_total", want.fault_total, got.fault_total);
    endfunction

endclass

module second_chance_page_replacement_core_tb;

    import scp_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_ready;
    logic [PAGE_W-1:0]      page_number;
    logic                   out_valid;
    logic                   out_ready;
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
    logic [FAULT_W-1:0]     fault_total;

    // when set, neither side inserts gaps or stalls
    bit quiet_mode = 1'b0;

    page_table_scoreboard page_table = new();

    second_chance_page_replacement_core #(
        .MAX_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

    // result side: random back-pressure, changed on the falling edge
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = quiet_mode ? 1'b1 : ($urandom_range(0, 99) >= 32);
        end
    end

    // every result transfer is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            page_table.check_result({hit, frame_index, evicted_valid,
                                     evicted_page, fault_total});
    end

    // one apb transfer: setup cycle, then access until pready
    task automatic apb_access(input bit is_write, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = ADDR_ACTIVE_FRAMES;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // read back the frame count register and compare with the predictor copy
    task automatic check_active_frames();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd[ACTIVE_W-1:0] !== page_table.active_frames)
        begin
            $display("%0t ERROR: active_frames readback expected 0x%0h got 0x%0h",
                     $time, page_table.active_frames, rd[ACTIVE_W-1:0]);
            page_table.mismatch_count++;
        end
    endtask

    // only called while the core is idle; upper data bits are don't-care
    task automatic program_active_frames(input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, value, rd);
        page_table.active_frames = value[ACTIVE_W-1:0];
        check_active_frames();
    endtask

    // present one reference, optionally after a gap, and hold it until the transfer
    task automatic send_reference(input logic [PAGE_W-1:0] page);
        @(negedge clk);
        while (!quiet_mode && $urandom_range(0, 99) < 32)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        page_number = page;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        page_table.note_reference(page);
    endtask

    task automatic end_stream();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // every reference yields one result, so an empty queue means the core is idle
    task automatic wait_results_drained();
        while (page_table.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [PAGE_W-1:0]     directed_pages [$];
        logic [PAGE_W-1:0]     working_set [$];
        logic [PAGE_W-1:0]     page;
        logic [APB_DATA_W-1:0] cfg_word;
        logic [31:0]           rnd;
        int                    phase_frames [10];
        int                    n_eff;
        int                    set_size;

        // all inputs known from time zero while reset is held low
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        page_number = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_active_frames();

        // directed: ten frames at reset, extreme page numbers, hits, a full
        // sweep that clears every bit, then a sweep that skips a re-hit frame
        directed_pages = '{20'h00000, 20'hFFFFF, 20'h00000, 20'hFFFFF,
                           20'h55555, 20'hAAAAA, 20'h00001, 20'h00002,
                           20'h00004, 20'h00008, 20'h80000, 20'h7FFFF,
                           20'h12345, 20'hFFFFF, 20'h23456, 20'h00000,
                           20'h7FFFF};
        foreach (directed_pages[i])
            send_reference(directed_pages[i]);
        end_stream();
        wait_results_drained();

        // frame counts per phase: full, single, zero (acts as one), out of
        // range high, small, just above max, random, reset value, three, full
        phase_frames = '{16, 1, 0, 31, 2, 17, -1, 10, 3, 16};
        for (int ph = 0; ph < 10; ph++)
        begin
            cfg_word = $urandom();
            if (phase_frames[ph] < 0)
                cfg_word[ACTIVE_W-1:0] = ACTIVE_W'($urandom_range(1, NUM_FRAMES));
            else
                cfg_word[ACTIVE_W-1:0] = ACTIVE_W'(phase_frames[ph]);
            program_active_frames(cfg_word);
            n_eff = (cfg_word[ACTIVE_W-1:0] == 0) ? 1 :
                    (cfg_word[ACTIVE_W-1:0] > NUM_FRAMES) ? NUM_FRAMES :
                    int'(cfg_word[ACTIVE_W-1:0]);

            // one phase runs with no gaps or stalls on either side
            quiet_mode = (ph == 4);

            // working set of n_eff to 2 * n_eff + 1 pages, so hits,
            // fills and sweeps all happen; the rest are arbitrary pages
            working_set.delete();
            set_size = n_eff + $urandom_range(0, n_eff + 1);
            for (int k = 0; k < set_size; k++)
            begin
                rnd = $urandom();
                working_set.push_back(rnd[PAGE_W-1:0]);
            end
            for (int k = 0; k < 150; k++)
            begin
                rnd = $urandom();
                if ($urandom_range(0, 99) < 80)
                    page = working_set[$urandom_range(0, working_set.size() - 1)];
                else
                    page = rnd[PAGE_W-1:0];
                send_reference(page);
            end
            end_stream();
            wait_results_drained();
            quiet_mode = 1'b0;
        end

        // quiet tail so a stray extra result would still be caught
        repeat (64) @(posedge clk);
        if (page_table.mismatch_count == 0 && page_table.expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
